// ===== sv/lkc_pkg.sv =====
// Shared types, constants and codes for the LRU key cache.
package lkc_pkg;

    localparam int ENTRIES = 16;
    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int CAP_W   = 5;
    localparam int KIND_W  = 2;
    localparam int OUTC_W  = 3;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd14;

    // Register index, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_TRIM   = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [OUTC_W-1:0] {
        OC_EVICT     = 3'd0,
        OC_HIT       = 3'd1,
        OC_INSERT    = 3'd2,
        OC_REMOVED   = 3'd3,
        OC_NOT_FOUND = 3'd4,
        OC_TRIM_DONE = 3'd5
    } t_outcome;

    typedef enum logic [1:0] {
        RK_NONE,
        RK_TOUCH,
        RK_DROP,
        RK_INSERT
    } t_rank_op;

    typedef struct packed {
        t_rank_op          op;
        logic [SLOT_W-1:0] slot;
    } t_rank_req;

    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [SLOT_W-1:0]  lru;
        logic [SLOT_W-1:0]  free_slot;
        logic [ENTRIES-1:0] valid;
    } t_rank_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVCHK,
        ST_EVOUT,
        ST_INS,
        ST_RESULT
    } t_state;

endpackage

// ===== sv/lkc_keys.sv =====
// Key store with registered read port and the shared key comparator.
module lkc_keys (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [lkc_pkg::SLOT_W-1:0] i_waddr,
    input  logic [lkc_pkg::KEY_W-1:0]  i_wdata,
    input  logic [lkc_pkg::SLOT_W-1:0] i_raddr,
    input  logic [lkc_pkg::KEY_W-1:0]  i_cmp_key,
    output logic [lkc_pkg::KEY_W-1:0]  o_rd_key,
    output logic                      o_match
);
    import lkc_pkg::*;

    logic [KEY_W-1:0] r_mem [ENTRIES];
    logic [KEY_W-1:0] r_rd_key;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_key <= r_mem[i_raddr];
    end

    assign o_rd_key = r_rd_key;
    // one slot compared per cycle against the item's key
    assign o_match  = (r_rd_key == i_cmp_key);

endmodule

// ===== sv/lkc_rank.sv =====
// Valid bits, recency ranks and entry count, with LRU and free-slot pick.
module lkc_rank (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lkc_pkg::t_rank_req    i_req,
    output lkc_pkg::t_rank_stat   o_stat
);
    import lkc_pkg::*;

    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [SLOT_W-1:0]  r_rank [ENTRIES];
    logic [SLOT_W-1:0]  n_rank [ENTRIES];
    logic [CNT_W-1:0]   r_count, n_count;
    logic [SLOT_W-1:0]  sel_rank;
    logic [SLOT_W-1:0]  oldest_rank;
    logic [SLOT_W-1:0]  lru;
    logic [SLOT_W-1:0]  free_slot;
    logic               lru_found;
    logic               free_found;

    assign sel_rank    = r_rank[i_req.slot];
    assign oldest_rank = SLOT_W'(r_count - 1'b1);

    // update every entry in parallel for the requested operation
    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_count = r_count;
        case (i_req.op)
            RK_TOUCH: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && r_rank[i] < sel_rank) begin
                        n_rank[i] = r_rank[i] + 1'b1;
                    end
                end
                n_rank[i_req.slot] = '0;
            end
            RK_DROP: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && SLOT_W'(i) != i_req.slot && r_rank[i] > sel_rank) begin
                        n_rank[i] = r_rank[i] - 1'b1;
                    end
                end
                n_valid[i_req.slot] = 1'b0;
                n_rank[i_req.slot]  = '0;
                n_count             = r_count - 1'b1;
            end
            RK_INSERT: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i]) begin
                        n_rank[i] = r_rank[i] + 1'b1;
                    end
                end
                n_valid[i_req.slot] = 1'b1;
                n_rank[i_req.slot]  = '0;
                n_count             = r_count + 1'b1;
            end
            default: ;
        endcase
    end

    // ranks form a permutation, so the oldest entry is the one at count-1
    always_comb begin
        lru        = '0;
        free_slot  = '0;
        lru_found  = 1'b0;
        free_found = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!lru_found && r_valid[i] && r_rank[i] == oldest_rank) begin
                lru       = SLOT_W'(i);
                lru_found = 1'b1;
            end
            if (!free_found && !r_valid[i]) begin
                free_slot  = SLOT_W'(i);
                free_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            r_rank  <= n_rank;
        end
    end

    assign o_stat.count     = r_count;
    assign o_stat.lru       = lru;
    assign o_stat.free_slot = free_slot;
    assign o_stat.valid     = r_valid;

endmodule

// ===== sv/lru_key_cache_with_resize.sv =====
// Top level of the LRU key cache: sequencer, key scan, output register, APB port.
//
// Usage
//   Input channel (i_in_valid / o_in_ready, i_kind, i_key) takes one command
//   beat: lookup-or-insert, remove, or trim; kind three is taken and dropped.
//   Output channel (o_out_valid / i_out_ready) gives one or more result beats per
//   command, o_last on the final one; a miss or trim first gives one eviction
//   beat per least-recent key dropped.
// Sequence
//   The single key comparator and key-store read port scan one slot per cycle:
//   a hit ends the scan, a remove miss ends it after the last slot. A lookup miss
//   (after the scan) or a trim (from accept) then, per eviction, picks and reads
//   the LRU key, then emits; the closing beat takes a final check, then an emit.
//   One command is in flight at a time; o_in_ready is high only between them.
// Reset and stall
//   Reset (i_rst_n low, synchronous) empties the cache and sets capacity to 14.
//   The result register holds its beat while i_out_ready is low; the sequencer
//   waits on it, and a new command is taken while the last beat still waits.
//   The user must write Capacity (register 0) over APB only while idle; the
//   block does not enforce this. pready is tied high.
module lru_key_cache_with_resize (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [lkc_pkg::KIND_W-1:0] i_kind,
    input  logic [lkc_pkg::KEY_W-1:0]  i_key,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [lkc_pkg::OUTC_W-1:0] o_outcome,
    output logic [lkc_pkg::KEY_W-1:0]  o_result_key,
    output logic [lkc_pkg::SLOT_W-1:0] o_slot,
    output logic [lkc_pkg::CNT_W-1:0]  o_held,
    output logic                       o_last,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lkc_pkg::APB_AW-1:0] paddr,
    input  logic [lkc_pkg::APB_DW-1:0] pwdata,
    output logic [lkc_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import lkc_pkg::*;

    t_state             r_state, n_state;
    logic [CAP_W-1:0]   r_cap;
    t_kind              r_kind;
    logic [KEY_W-1:0]   r_key;
    logic [CNT_W-1:0]   r_limit;
    logic [SLOT_W:0]    r_idx;
    logic               r_cmp_vld;
    logic [SLOT_W-1:0]  r_cmp_slot;
    logic               r_hit;
    logic [SLOT_W-1:0]  r_slot;

    logic               r_out_valid;
    t_outcome           r_out_outcome;
    logic [KEY_W-1:0]   r_out_key;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [CNT_W-1:0]   r_out_held;
    logic               r_out_last;

    t_outcome           n_out_outcome;
    logic [SLOT_W-1:0]  n_out_slot;
    logic [KEY_W-1:0]   n_out_key;
    logic [CNT_W-1:0]   n_out_held;
    logic               n_out_last;

    t_kind              in_kind;
    logic               in_accept;
    logic               out_free;
    logic               emit;
    logic [CNT_W-1:0]   cap_eff;
    logic               scan_hit;
    logic               scan_end;
    logic               over_limit;
    logic               apb_write;

    t_rank_req          rank_req;
    t_rank_stat         stat;
    logic [SLOT_W-1:0]  rd_addr;
    logic [KEY_W-1:0]   rd_key;
    logic               key_match;
    logic               key_we;

    lkc_keys u_keys (
        .i_clk     (i_clk),
        .i_we      (key_we),
        .i_waddr   (stat.free_slot),
        .i_wdata   (r_key),
        .i_raddr   (rd_addr),
        .i_cmp_key (r_key),
        .o_rd_key  (rd_key),
        .o_match   (key_match)
    );

    lkc_rank u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rank_req),
        .o_stat  (stat)
    );

    assign in_kind    = t_kind'(i_kind);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign over_limit = stat.count > r_limit;

    // zero counts as one, anything above the store size as the store size
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CNT_W'(1);
        end else if (32'(r_cap) > ENTRIES) begin
            cap_eff = CNT_W'(ENTRIES);
        end else begin
            cap_eff = CNT_W'(r_cap);
        end
    end

    // compare stage holds the key read for r_cmp_slot
    assign scan_hit = r_cmp_vld && stat.valid[r_cmp_slot] && key_match;
    assign scan_end = r_cmp_vld && (r_cmp_slot == SLOT_W'(ENTRIES - 1)) && !scan_hit;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && in_kind != KIND_NONE) begin
                    n_state = (in_kind == KIND_TRIM) ? ST_EVCHK : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    n_state = ST_RESULT;
                end else if (scan_end) begin
                    n_state = (r_kind == KIND_LOOKUP) ? ST_EVCHK : ST_RESULT;
                end
            end
            ST_EVCHK: begin
                if (over_limit) begin
                    n_state = ST_EVOUT;
                end else begin
                    n_state = (r_kind == KIND_LOOKUP) ? ST_INS : ST_RESULT;
                end
            end
            ST_EVOUT: begin
                if (out_free) begin
                    n_state = ST_EVCHK;
                end
            end
            ST_INS, ST_RESULT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: read address, result beat, bookkeeping request
    always_comb begin
        o_in_ready    = 1'b0;
        emit          = 1'b0;
        key_we        = 1'b0;
        rd_addr       = r_slot;
        rank_req.op   = RK_NONE;
        rank_req.slot = r_slot;
        n_out_outcome = OC_TRIM_DONE;
        n_out_key     = r_key;
        n_out_slot    = '0;
        n_out_held    = stat.count;
        n_out_last    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_SCAN: begin
                rd_addr = r_idx[SLOT_W-1:0];
            end
            ST_EVCHK: begin
                rd_addr = stat.lru;
            end
            ST_EVOUT: begin
                emit          = out_free;
                n_out_outcome = OC_EVICT;
                n_out_key     = rd_key;
                n_out_slot    = r_slot;
                n_out_held    = stat.count - 1'b1;
                n_out_last    = 1'b0;
                if (out_free) begin
                    rank_req.op = RK_DROP;
                end
            end
            ST_INS: begin
                emit          = out_free;
                key_we        = out_free;
                n_out_outcome = OC_INSERT;
                n_out_slot    = stat.free_slot;
                n_out_held    = stat.count + 1'b1;
                rank_req.slot = stat.free_slot;
                if (out_free) begin
                    rank_req.op = RK_INSERT;
                end
            end
            ST_RESULT: begin
                emit = out_free;
                case (r_kind)
                    KIND_LOOKUP: begin
                        n_out_outcome = OC_HIT;
                        n_out_slot    = r_slot;
                        if (out_free) begin
                            rank_req.op = RK_TOUCH;
                        end
                    end
                    KIND_REMOVE: begin
                        if (r_hit) begin
                            n_out_outcome = OC_REMOVED;
                            n_out_slot    = r_slot;
                            n_out_held    = stat.count - 1'b1;
                            if (out_free) begin
                                rank_req.op = RK_DROP;
                            end
                        end else begin
                            n_out_outcome = OC_NOT_FOUND;
                        end
                    end
                    default: n_out_outcome = OC_TRIM_DONE;
                endcase
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            if (apb_write && paddr[2] == REG_CAPACITY) begin
                r_cap <= pwdata[CAP_W-1:0];
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_accept) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
                r_hit     <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                // issue one read per cycle until every slot has been sent
                if (r_idx != (SLOT_W + 1)'(ENTRIES)) begin
                    r_idx      <= r_idx + 1'b1;
                    r_cmp_vld  <= 1'b1;
                end else begin
                    r_cmp_vld  <= 1'b0;
                end
                if (scan_hit) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind  <= in_kind;
            r_key   <= i_key;
            r_limit <= (in_kind == KIND_LOOKUP) ? (cap_eff - 1'b1) : cap_eff;
        end
        if (r_state == ST_SCAN) begin
            r_cmp_slot <= r_idx[SLOT_W-1:0];
            if (scan_hit) begin
                r_slot <= r_cmp_slot;
            end
        end
        if (r_state == ST_EVCHK) begin
            r_slot <= stat.lru;
        end
        if (emit) begin
            r_out_outcome <= n_out_outcome;
            r_out_key     <= n_out_key;
            r_out_slot    <= n_out_slot;
            r_out_held    <= n_out_held;
            r_out_last    <= n_out_last;
        end
    end

    // APB: single register, always ready
    assign apb_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_CAPACITY) ? APB_DW'(r_cap) : '0;

    assign o_out_valid  = r_out_valid;
    assign o_outcome    = r_out_outcome;
    assign o_result_key = r_out_key;
    assign o_slot       = r_out_slot;
    assign o_held       = r_out_held;
    assign o_last       = r_out_last;

    // an insert always finds a free slot after eviction
    a_ins_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS && emit) |-> !(&stat.valid))
        else $error("insert with no free slot");

    // only eviction beats are not final
    a_last_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_out_outcome == OC_EVICT))
        else $error("non-final beat is not an eviction");

    // held count in a beat matches the bookkeeping after its update
    a_held_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_out_held == stat.count))
        else $error("held count disagrees with entry count");

    // a drop removes exactly one entry
    a_drop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rank_req.op == RK_DROP) |=> (stat.count == $past(stat.count) - 1'b1))
        else $error("drop did not decrement the count");

    // the count never exceeds the store size and matches the number of valid bits
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(stat.count) <= ENTRIES) && ($countones(stat.valid) == 32'(stat.count)))
        else $error("entry count out of step with valid bits");

endmodule
